### hdl/xorshift_ranged_random_assert.svh
// Assertion macros for the ranged xorshift generator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef XORSHIFT_RANGED_RANDOM_ASSERT_SVH
`define XORSHIFT_RANGED_RANDOM_ASSERT_SVH

`ifndef SYNTHESIS
`define XRR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("xrr assertion failed");
`define XRR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xrr implication failed");
`else
`define XRR_ASSERT(label, prop)
`define XRR_ASSERT_IMPL(label, ante, cons)
`endif

`endif

### hdl/xrr_pkg.sv
`timescale 1ns / 1ps

package xrr_pkg;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               empty_range;
    } out_item_t;

    localparam logic [31:0] WORD_Y_INIT = 32'd842502087;
    localparam logic [31:0] WORD_Z_INIT = 32'd3579807591;
    localparam logic [31:0] WORD_W_INIT = 32'd273326509;
    localparam logic [30:0] DRAW_REJECT = 31'h7FFF_FFFF;

    // Dividend of the ranged draw is the 31-bit draw shifted right by two.
    localparam int DIVIDEND_W = 29;
    localparam int DIVISOR_W  = 32;
    localparam int STEP_W     = 5;

endpackage

### hdl/xrr_gen.sv
`timescale 1ns / 1ps

module xrr_gen (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_load,
    input  logic [31:0] seed,
    input  logic        advance,
    output logic [30:0] draw_next
);
    import xrr_pkg::*;

    logic [31:0] x_reg, y_reg, z_reg, w_reg;
    logic [31:0] t_mix;
    logic [31:0] w_next;

    always_comb
    begin
        t_mix     = x_reg ^ (x_reg << 11);
        w_next    = (w_reg ^ (w_reg >> 19)) ^ (t_mix ^ (t_mix >> 8));
        draw_next = w_next[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= WORD_Y_INIT;
            z_reg <= WORD_Z_INIT;
            w_reg <= WORD_W_INIT;
        end
        else if (seed_load)
        begin
            x_reg <= seed;
            y_reg <= WORD_Y_INIT;
            z_reg <= WORD_Z_INIT;
            w_reg <= WORD_W_INIT;
        end
        else if (advance)
        begin
            x_reg <= y_reg;
            y_reg <= z_reg;
            z_reg <= w_reg;
            w_reg <= w_next;
        end
    end

endmodule

### hdl/xrr_div.sv
`timescale 1ns / 1ps

module xrr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [xrr_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [xrr_pkg::DIVISOR_W-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [xrr_pkg::DIVISOR_W-1:0]  remainder
);
    import xrr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     count_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;
    logic [DIVISOR_W-1:0]  rem_next;

    // Restoring step: bring in one dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff     = {1'b0, trial} - {2'b00, divisor_reg};
        rem_next = diff[DIVISOR_W+1] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= STEP_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - STEP_W'(1);
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hdl/xorshift_ranged_random.sv
`timescale 1ns / 1ps

// Ranged xorshift128 random number source.
// Input channel (in_valid / in_stall / in_data): one request per transaction,
// operation 0 asks for a raw 31-bit draw, operation 1 for a draw in
// [lower_bound, upper_bound); reversed bounds are swapped, equal bounds give
// lower_bound with empty_range set.
// Output channel (out_valid / out_stall / out_data): one result per request.
// Seed port: pulse seed_wr_en with seed_wr_data while no request is in flight;
// the write reloads all four generator words.
// Flow: a raw draw or an empty range goes from acceptance through the draw and
// done states to out_valid; a ranged draw also passes the 29-step restoring
// modulo unit (one quotient bit per cycle). Each rejected all-ones draw makes
// the block draw again. The block holds in_stall high from acceptance until
// its result is in the output register, taking no new request before that.
// Reset: generator words return to their seed-zero values, nothing is pending.
// Receiver stall: the result waits in the output register; the block takes
// the next request meanwhile and holds its new result until the register frees.
module xorshift_ranged_random (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  xrr_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output xrr_pkg::out_item_t out_data,
    input  logic              seed_wr_en,
    input  logic [31:0]       seed_wr_data
);
    import xrr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DRAW = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;

    // Request held for the transaction in flight.
    logic        op_reg;
    logic        empty_reg;
    logic [31:0] lo_reg;
    logic [31:0] range_reg;
    logic [31:0] result_reg;

    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        accept;
    logic        gen_advance;
    logic [30:0] draw_next;
    logic        draw_ok;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_rem;
    logic        out_free;

    logic signed [31:0] lo_sel, hi_sel;
    logic [32:0]        range_wide;

    xrr_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_load (seed_wr_en),
        .seed      (seed_wr_data),
        .advance   (gen_advance),
        .draw_next (draw_next)
    );

    xrr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (draw_next[30:2]),
        .divisor   (range_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Order the bounds and take their difference one bit wider so it never wraps.
    always_comb
    begin
        if (in_data.lower_bound > in_data.upper_bound)
        begin
            lo_sel = in_data.upper_bound;
            hi_sel = in_data.lower_bound;
        end
        else
        begin
            lo_sel = in_data.lower_bound;
            hi_sel = in_data.upper_bound;
        end
        range_wide = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign gen_advance = (state_reg == S_DRAW);
    assign draw_ok     = (draw_next != DRAW_REJECT);
    assign div_start   = gen_advance && draw_ok && op_reg && !empty_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Sequencer: draw until a non-reject value, divide a non-empty range, deliver.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DRAW;
            end
            S_DRAW:
            begin
                if (draw_ok)
                    state_next = div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Drop the result once taken; load the next one when the slot is free.
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: capture the request, then the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_data.operation;
            empty_reg <= in_data.operation && (range_wide == '0);
            lo_reg    <= lo_sel;
            range_reg <= range_wide[31:0];
        end
        if (state_reg == S_DRAW && draw_ok)
        begin
            if (!op_reg)
                result_reg <= {1'b0, draw_next};
            else
                result_reg <= lo_reg;
        end
        if (state_reg == S_DIV && div_done)
            result_reg <= lo_reg + div_rem;
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.value       <= result_reg;
            out_data_reg.empty_range <= empty_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "xorshift_ranged_random_assert.svh"

    `XRR_ASSERT(a_accept_starts_draw, accept |=> (state_reg == S_DRAW))
    `XRR_ASSERT_IMPL(a_div_only_in_div, div_busy, state_reg == S_DIV)
    `XRR_ASSERT(a_done_delivers, (state_reg == S_DONE && out_free) |=> out_valid)

endmodule

### tb/xrr_test_pkg.sv
`timescale 1ns / 1ps

package xrr_test_pkg;

    typedef enum logic {
        OP_RAW    = 1'b0,
        OP_RANGED = 1'b1
    } op_code_t;

endpackage

### tb/xorshift_ranged_random_check.sv
`timescale 1ns / 1ps

module xorshift_ranged_random_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  xrr_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  xrr_pkg::out_item_t out_data,
    input  logic               seed_wr_en,
    input  logic [31:0]        seed_wr_data,
    output int                 mismatch_count,
    output int                 results_pending
);

    import xrr_pkg::*;
    import xrr_test_pkg::*;

    logic [31:0] word_x = 32'd0;
    logic [31:0] word_y = WORD_Y_INIT;
    logic [31:0] word_z = WORD_Z_INIT;
    logic [31:0] word_w = WORD_W_INIT;

    out_item_t expected_results[$];
    int        mismatches   = 0;
    int        result_index = 0;

    task automatic reload_words(input logic [31:0] seed);
        word_x = seed;
        word_y = WORD_Y_INIT;
        word_z = WORD_Z_INIT;
        word_w = WORD_W_INIT;
    endtask

    // Advance until the low 31 bits are not all ones.
    task automatic next_draw(output logic [30:0] draw);
        logic [31:0] t;
        do
        begin
            t      = word_x ^ (word_x << 11);
            word_x = word_y;
            word_y = word_z;
            word_z = word_w;
            word_w = (word_w ^ (word_w >> 19)) ^ (t ^ (t >> 8));
            draw   = word_w[30:0];
        end
        while (draw == DRAW_REJECT);
    endtask

    task automatic predict_draw(input in_item_t req, output out_item_t res);
        logic [30:0]        draw;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        longint             span;
        longint             offset;
        next_draw(draw);
        res.empty_range = 1'b0;
        if (req.operation == OP_RAW)
        begin
            res.value = {1'b0, draw};
        end
        else
        begin
            lo = req.lower_bound;
            hi = req.upper_bound;
            if (lo > hi)
            begin
                lo = req.upper_bound;
                hi = req.lower_bound;
            end
            // 64-bit span never wraps, full signed range included
            span = longint'(hi) - longint'(lo);
            if (span == 0)
            begin
                res.value       = lo;
                res.empty_range = 1'b1;
            end
            else
            begin
                offset    = longint'({33'd0, draw >> 2}) % span;
                res.value = 32'(longint'(lo) + offset);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t res;
        if (!rst_n)
        begin
            reload_words(32'd0);
            expected_results.delete();
        end
        else
        begin
            if (seed_wr_en)
                reload_words(seed_wr_data);

            // Compare before pushing so a result can never match its own request.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result value=%0h empty=%0b",
                                              out_data.value, out_data.empty_range));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.value !== want.value)
                        report_mismatch($sformatf("value got %0h expected %0h",
                                                  out_data.value, want.value));
                    if (out_data.empty_range !== want.empty_range)
                        report_mismatch($sformatf("empty_range got %0b expected %0b",
                                                  out_data.empty_range, want.empty_range));
                end
                result_index++;
            end

            if (in_valid && !in_stall)
            begin
                predict_draw(in_data, res);
                expected_results.push_back(res);
            end
        end
        mismatch_count  <= mismatches;
        results_pending <= expected_results.size();
    end

endmodule

### tb/xorshift_ranged_random_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the ranged xorshift generator. Prediction and
// comparison live in the checker instantiated below; this module only drives
// requests, seed writes and receiver stalls.
module xorshift_ranged_random_test;

    import xrr_pkg::*;
    import xrr_test_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int DRAIN_CYCLES  = 40;
    // Idle cycles before a seed write: the block has nothing in flight once
    // every result is back, but leave a margin.
    localparam int SETTLE_CYCLES = 4;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    in_item_t    in_data      = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    out_item_t   out_data;
    logic        seed_wr_en   = 1'b0;
    logic [31:0] seed_wr_data = 32'd0;

    int          mismatch_count;
    int          results_pending;
    int          cycle_count  = 0;
    int          burst_left   = 0;

    xorshift_ranged_random dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data)
    );

    xorshift_ranged_random_check checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .seed_wr_en      (seed_wr_en),
        .seed_wr_data    (seed_wr_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop: the slowest correct run (ranged draws, the longest sender gaps,
    // the longest receiver stalls on every transaction) stays far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_idle(input int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, long_max);
    endfunction

    // Receiver: alternate stall and free stretches; occasionally run free for
    // a long stretch so back-to-back results drain without any hold.
    initial
    begin
        int hold_len;
        int free_len;
        @(posedge clk iff rst_n);
        forever
        begin
            hold_len = pick_idle(60);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
            end
            free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : pick_idle(20);
            repeat (free_len + 1) @(posedge clk);
        end
    end

    // Present one request after a gap and hold it until a transaction happens.
    // Valid stays high across back-to-back requests.
    task automatic send_request(input in_item_t req, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic in_item_t make_request(input op_code_t op,
                                              input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
        in_item_t req;
        req.operation   = op;
        req.lower_bound = lo;
        req.upper_bound = hi;
        return req;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return S32_MIN + 32'sd1;
        endcase
    endfunction

    // Random request mix: raw draws, narrow and wide ranges, equal bounds and
    // extremes, with bounds randomly reversed.
    function automatic in_item_t make_random_request();
        int                 r;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        r  = $urandom_range(0, 99);
        lo = $urandom;
        hi = $urandom;
        if (r < 25)
            return make_request(OP_RAW, lo, hi);
        if (r < 42)
            hi = lo + $urandom_range(1, 16);
        else if (r < 52)
            hi = lo;
        else if (r < 57)
        begin
            lo = pick_extreme();
            hi = lo;
        end
        else if (r < 72)
        begin
            lo = pick_extreme();
            hi = pick_extreme();
        end
        else if (r < 84)
            hi = lo + $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1) == 1)
            return make_request(OP_RANGED, hi, lo);
        return make_request(OP_RANGED, lo, hi);
    endfunction

    // Sender gap with bursts of back-to-back requests mixed in.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(20, 40);
        return pick_idle(40);
    endfunction

    // Wait one edge first so the pending count includes the last transaction.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reseed only while idle; the write reloads all four generator words.
    task automatic write_seed(input logic [31:0] seed);
        wait_idle();
        seed_wr_en   <= 1'b1;
        seed_wr_data <= seed;
        @(posedge clk);
        seed_wr_en   <= 1'b0;
        seed_wr_data <= $urandom;
    endtask

    initial
    begin
        in_item_t    directed[$];
        logic [31:0] seeds[4];
        int          phase_items;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the reset seed of zero.
        directed.push_back(make_request(OP_RAW,    32'sd0,  32'sd0));
        directed.push_back(make_request(OP_RAW,    S32_MIN, S32_MAX));
        directed.push_back(make_request(OP_RAW,    -32'sd1, -32'sd1));
        // widest range, both orders: the span needs the extra bit
        directed.push_back(make_request(OP_RANGED, S32_MIN, S32_MAX));
        directed.push_back(make_request(OP_RANGED, S32_MAX, S32_MIN));
        directed.push_back(make_request(OP_RANGED, S32_MIN, -32'sd1));
        directed.push_back(make_request(OP_RANGED, -32'sd1, S32_MAX));
        // equal bounds: generator still advances, result is the bound
        directed.push_back(make_request(OP_RANGED, 32'sd0,  32'sd0));
        directed.push_back(make_request(OP_RANGED, S32_MAX, S32_MAX));
        directed.push_back(make_request(OP_RANGED, S32_MIN, S32_MIN));
        directed.push_back(make_request(OP_RANGED, -32'sd1, -32'sd1));
        // span of one always returns the lower bound
        directed.push_back(make_request(OP_RANGED, 32'sd0,  32'sd1));
        directed.push_back(make_request(OP_RANGED, 32'sd1,  32'sd0));
        directed.push_back(make_request(OP_RANGED, S32_MAX - 32'sd1, S32_MAX));
        directed.push_back(make_request(OP_RANGED, S32_MIN, S32_MIN + 32'sd1));
        // reversed bounds across zero and small ranges
        directed.push_back(make_request(OP_RANGED, 32'sd100, -32'sd100));
        directed.push_back(make_request(OP_RANGED, -32'sd7,  32'sd9));
        directed.push_back(make_request(OP_RANGED, 32'sd1000, 32'sd1003));
        directed.push_back(make_request(OP_RANGED, 32'sh5555_5555, 32'shAAAA_AAAA));
        directed.push_back(make_request(OP_RAW,    32'shAAAA_AAAA, 32'sh5555_5555));
        foreach (directed[i])
            send_request(directed[i], pick_idle(10));

        // Random part over several seeds, extremes included. An all-zero
        // generator state cannot be reached by any seed, so it is not tried.
        seeds[0] = 32'hFFFF_FFFF;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom;
        seeds[3] = $urandom;
        phase_items = RANDOM_ITEMS / 4;
        foreach (seeds[p])
        begin
            write_seed(seeds[p]);
            repeat (phase_items)
                send_request(make_random_request(), next_gap());
        end
        in_valid <= 1'b0;

        // Drain: the timeout catches results that never arrive.
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### xorshift_ranged_random.f
+incdir+hdl
hdl/xrr_pkg.sv
hdl/xrr_gen.sv
hdl/xrr_div.sv
hdl/xorshift_ranged_random.sv
tb/xrr_test_pkg.sv
tb/xorshift_ranged_random_check.sv
tb/xorshift_ranged_random_test.sv
